@@ hdl/mpdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_pkg
// Shared types, codes and constants of the metered pump dispense controller.
// ----------------------------------------------------------------------------
package mpdc_pkg;

    localparam int          NUM_BANDS    = 4;
    localparam int          DFLT_PUMPS   = 9;
    localparam logic [3:0]  TIMED_PUMP   = 4'd7;

    localparam logic [15:0] VOL_SMALL    = 16'd50;
    localparam logic [15:0] VOL_MEDIUM   = 16'd100;
    localparam logic [15:0] VOL_LARGE    = 16'd150;

    // configuration reset values
    localparam logic [15:0] RST_NO_FLOW  = 16'd2000;
    localparam logic [15:0] RST_EDGE_LO  = 16'd50;
    localparam logic [15:0] RST_EDGE_MID = 16'd100;
    localparam logic [15:0] RST_EDGE_HI  = 16'd150;
    localparam logic [15:0] RST_T_SMALL  = 16'd6236;
    localparam logic [15:0] RST_T_MEDIUM = 16'd12208;
    localparam logic [15:0] RST_T_LARGE  = 16'd18400;

    typedef enum logic [2:0] {
        CFG_NO_FLOW   = 3'd0,
        CFG_EDGE_LO   = 3'd1,
        CFG_EDGE_MID  = 3'd2,
        CFG_EDGE_HI   = 3'd3,
        CFG_T_SMALL   = 3'd4,
        CFG_T_MEDIUM  = 3'd5,
        CFG_T_LARGE   = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_PULSE = 3'd1,
        OP_START = 3'd2,
        OP_STOP  = 3'd3,
        OP_CAL   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STARTED  = 3'd1,
        EV_VOLUME   = 3'd2,
        EV_NO_FLOW  = 3'd3,
        EV_TIME     = 3'd4,
        EV_REJECT   = 3'd5,
        EV_STOPPED  = 3'd6,
        EV_CAL      = 3'd7
    } t_event;

    // decoded item held in the input stage
    typedef struct packed {
        t_op         op;
        logic [3:0]  pump;
        logic [15:0] vol;
        logic        start_ok;  // start is legal (pump range, timed volume)
        logic        cal_ok;    // calibration write is legal
        logic [15:0] dur;       // timed run length, zero for metered pumps
    } t_item;

    typedef struct packed {
        logic        pump_on;
        logic [3:0]  active_pump;
        t_event      event_code;
        logic [31:0] pulse_count;
        logic [15:0] elapsed_ms;
    } t_result;

    // factory calibration, Q8.8 pulses per mL, row per pump, band 0..3
    localparam logic [15:0] DFLT_FACTORS [DFLT_PUMPS*NUM_BANDS] = '{
        16'd4608, 16'd5888, 16'd7680, 16'd12800,
        16'd486,  16'd486,  16'd486,  16'd486,
        16'd614,  16'd1331, 16'd1408, 16'd1408,
        16'd768,  16'd2227, 16'd2560, 16'd2560,
        16'd2048, 16'd3328, 16'd3840, 16'd3840,
        16'd1050, 16'd1203, 16'd1326, 16'd1423,
        16'd1050, 16'd799,  16'd599,  16'd438,
        16'd0,    16'd0,    16'd0,    16'd0,
        16'd8013, 16'd8013, 16'd7629, 16'd7296
    };

    function automatic logic [15:0] dflt_factor(input logic [5:0] idx);
        logic [15:0] f;
        f = 16'd0;
        if (idx < 6'(DFLT_PUMPS*NUM_BANDS)) begin
            f = DFLT_FACTORS[idx];
        end
        return f;
    endfunction

endpackage

@@ hdl/mpdc_cal_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_cal_mem
// Calibration factor store: one write, one registered read per cycle.
// Entries never written read as the factory factor.
// ----------------------------------------------------------------------------
module mpdc_cal_mem
    import mpdc_pkg::*;
#(
    parameter int NUM_PUMPS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [3:0]  i_wr_pump,
    input  logic [1:0]  i_wr_band,
    input  logic [15:0] i_wr_data,
    input  logic        i_rd_en,
    input  logic [3:0]  i_rd_pump,
    input  logic [1:0]  i_rd_band,
    output logic [15:0] o_rd_data
);

    localparam int DEPTH = NUM_PUMPS * NUM_BANDS;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [15:0]      r_rd_data;

    logic [5:0]    wr_full;
    logic [5:0]    rd_full;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_full = {i_wr_pump, i_wr_band};
    assign rd_full = {i_rd_pump, i_rd_band};
    assign wr_addr = wr_full[AW-1:0];
    assign rd_addr = rd_full[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[rd_addr] ? r_mem[rd_addr] : dflt_factor(rd_full);
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/mpdc_run_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_run_ctrl
// Run state and result register: one item per step, counters saturate.
// ----------------------------------------------------------------------------
module mpdc_run_ctrl
    import mpdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  logic [15:0] i_factor,
    input  logic [15:0] i_no_flow_limit,
    output t_result     o_result
);

    logic        r_running,  n_running;
    logic [3:0]  r_active,   n_active;
    logic [31:0] r_pulse,    n_pulse;
    logic [15:0] r_idle_ms,  n_idle_ms;
    logic [15:0] r_run_ms,   n_run_ms;
    logic [15:0] r_dur,      n_dur;
    logic [31:0] r_target,   n_target;
    t_result     r_result;

    t_event      ev;
    logic        timed;
    logic [15:0] run_inc;
    logic [15:0] idle_inc;
    logic [31:0] pulse_inc;
    logic        reached_tick;
    logic        reached_pulse;
    logic [31:0] product;

    always_comb begin
        n_running = r_running;
        n_active  = r_active;
        n_pulse   = r_pulse;
        n_idle_ms = r_idle_ms;
        n_run_ms  = r_run_ms;
        n_dur     = r_dur;
        n_target  = r_target;
        ev        = EV_NONE;

        timed     = r_running && (r_active == TIMED_PUMP);
        run_inc   = (r_run_ms  == 16'hFFFF) ? r_run_ms  : r_run_ms  + 16'd1;
        idle_inc  = (r_idle_ms == 16'hFFFF) ? r_idle_ms : r_idle_ms + 16'd1;
        pulse_inc = (r_pulse == 32'hFFFF_FFFF) ? r_pulse : r_pulse + 32'd1;
        // pulses*256 >= target, where target = volume*factor
        reached_tick  = {r_pulse, 8'h00}   >= {8'h00, r_target};
        reached_pulse = {pulse_inc, 8'h00} >= {8'h00, r_target};
        product       = {16'h0000, i_item.vol} * {16'h0000, i_factor};

        unique case (i_item.op)
            OP_TICK: begin
                if (r_running) begin
                    n_run_ms  = run_inc;
                    n_idle_ms = idle_inc;
                    if (timed) begin
                        if (run_inc >= r_dur) begin
                            n_running = 1'b0;
                            ev        = EV_TIME;
                        end
                    end else if (reached_tick) begin
                        n_running = 1'b0;
                        ev        = EV_VOLUME;
                    end else if (idle_inc > i_no_flow_limit) begin
                        n_running = 1'b0;
                        ev        = EV_NO_FLOW;
                    end
                end
            end
            OP_PULSE: begin
                if (r_running && !timed) begin
                    n_pulse   = pulse_inc;
                    n_idle_ms = 16'd0;
                    if (reached_pulse) begin
                        n_running = 1'b0;
                        ev        = EV_VOLUME;
                    end
                end
            end
            OP_START: begin
                n_running = 1'b0;
                ev        = EV_REJECT;
                if (i_item.start_ok) begin
                    n_target  = product;
                    n_dur     = i_item.dur;
                    n_pulse   = 32'd0;
                    n_idle_ms = 16'd0;
                    n_run_ms  = 16'd0;
                    n_active  = i_item.pump;
                    n_running = 1'b1;
                    ev        = EV_STARTED;
                end
            end
            OP_STOP: begin
                n_running = 1'b0;
                ev        = EV_STOPPED;
            end
            OP_CAL: begin
                n_running = 1'b0;
                ev        = i_item.cal_ok ? EV_CAL : EV_REJECT;
            end
            default: begin
                // unused codes: no change
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_active  <= 4'd0;
            r_pulse   <= 32'd0;
            r_idle_ms <= 16'd0;
            r_run_ms  <= 16'd0;
            r_dur     <= 16'd0;
            r_target  <= 32'd0;
        end else if (i_step) begin
            r_running <= n_running;
            r_active  <= n_active;
            r_pulse   <= n_pulse;
            r_idle_ms <= n_idle_ms;
            r_run_ms  <= n_run_ms;
            r_dur     <= n_dur;
            r_target  <= n_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_result.pump_on     <= n_running;
            r_result.active_pump <= n_active;
            r_result.event_code  <= ev;
            r_result.pulse_count <= n_pulse;
            r_result.elapsed_ms  <= n_run_ms;
        end
    end

    assign o_result = r_result;

endmodule

@@ hdl/metered_pump_dispense_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metered_pump_dispense_controller_core
// Event-driven controller for one pump at a time: metered runs by flow
// pulses against a calibrated target, a timed pump, no-flow fault.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transfer (tick, flow pulse, start, stop,
//   calibration write); m_axis returns exactly one status per event, in order.
//   Configuration is a plain write port (i_cfg_we / i_cfg_idx / i_cfg_wdata),
//   written by the user only while no event is in flight (not enforced by the
//   block itself); unknown indexes are dropped.
// Stages: input (calibration read), then run-state update into result register.
// Throughput: 1 event per cycle while m_axis_tready is high; widest path is the
//   40-bit pulse*256 >= target compare after the saturating pulse increment.
// Reset (synchronous, i_rst_n low): run stopped, counters and target cleared,
//   config back to defaults, calibration valid bits cleared at once so every
//   entry reads its factory factor; no clearing pass.
// Stall: the result register holds while m_axis_tready is low; one more
//   event is taken into the input stage, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module metered_pump_dispense_controller_core
    import mpdc_pkg::*;
#(
    parameter int NUM_PUMPS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    // event stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // pump_sel[3:0], volume_ml[19:4],
                                        // band_sel[21:20], cal_value[37:22], pad
    input  logic [2:0]  s_axis_tuser,   // operation[2:0]
    // status stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pump_on[0], active_pump[4:1],
                                        // pulse_count[36:5], elapsed_ms[52:37], pad
    output logic [2:0]  m_axis_tuser    // event_code[2:0]
);

    // configuration registers
    logic [15:0] r_no_flow;
    logic [15:0] r_edge_lo;
    logic [15:0] r_edge_mid;
    logic [15:0] r_edge_hi;
    logic [15:0] r_t_small;
    logic [15:0] r_t_medium;
    logic [15:0] r_t_large;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_flow  <= RST_NO_FLOW;
            r_edge_lo  <= RST_EDGE_LO;
            r_edge_mid <= RST_EDGE_MID;
            r_edge_hi  <= RST_EDGE_HI;
            r_t_small  <= RST_T_SMALL;
            r_t_medium <= RST_T_MEDIUM;
            r_t_large  <= RST_T_LARGE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NO_FLOW:  r_no_flow  <= i_cfg_wdata;
                CFG_EDGE_LO:  r_edge_lo  <= i_cfg_wdata;
                CFG_EDGE_MID: r_edge_mid <= i_cfg_wdata;
                CFG_EDGE_HI:  r_edge_hi  <= i_cfg_wdata;
                CFG_T_SMALL:  r_t_small  <= i_cfg_wdata;
                CFG_T_MEDIUM: r_t_medium <= i_cfg_wdata;
                CFG_T_LARGE:  r_t_large  <= i_cfg_wdata;
                default: begin
                    // index out of range: ignored
                end
            endcase
        end
    end

    // input field unpack
    t_op         in_op;
    logic [3:0]  in_pump;
    logic [15:0] in_vol;
    logic [1:0]  in_band;
    logic [15:0] in_cal;

    assign in_op   = t_op'(s_axis_tuser);
    assign in_pump = s_axis_tdata[3:0];
    assign in_vol  = s_axis_tdata[19:4];
    assign in_band = s_axis_tdata[21:20];
    assign in_cal  = s_axis_tdata[37:22];

    // handshake: input stage -> result register
    logic r_a_valid;
    logic r_out_valid;
    logic out_free;
    logic step;
    logic accept;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_a_valid && out_free;
    assign s_axis_tready = !r_a_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (step) begin
                r_a_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // decode: pump range, band pick, timed volume
    logic        pump_ok;
    logic        is_timed;
    logic [1:0]  band;
    logic        timed_ok;
    logic [15:0] dur;
    t_item       item;
    t_item       r_item;

    assign pump_ok  = {1'b0, in_pump} < 5'(NUM_PUMPS);
    assign is_timed = in_pump == TIMED_PUMP;

    always_comb begin
        if (in_vol <= r_edge_lo) begin
            band = 2'd0;
        end else if (in_vol <= r_edge_mid) begin
            band = 2'd1;
        end else if (in_vol <= r_edge_hi) begin
            band = 2'd2;
        end else begin
            band = 2'd3;
        end
    end

    always_comb begin
        timed_ok = 1'b1;
        dur      = 16'd0;
        if (is_timed) begin
            if (in_vol == VOL_SMALL) begin
                dur = r_t_small;
            end else if (in_vol == VOL_MEDIUM) begin
                dur = r_t_medium;
            end else if (in_vol == VOL_LARGE) begin
                dur = r_t_large;
            end else begin
                timed_ok = 1'b0;
            end
        end
    end

    always_comb begin
        item.op       = in_op;
        item.pump     = in_pump;
        item.vol      = in_vol;
        item.start_ok = pump_ok && timed_ok;
        item.cal_ok   = pump_ok && !is_timed && (in_cal != 16'd0);
        item.dur      = dur;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= item;
        end
    end

    // calibration store: write at transfer, read for a start with the pump in range
    logic        cal_we;
    logic        cal_rd;
    logic [15:0] factor;

    assign cal_we = accept && (in_op == OP_CAL) && item.cal_ok;
    assign cal_rd = accept && (in_op == OP_START) && pump_ok;

    mpdc_cal_mem #(
        .NUM_PUMPS (NUM_PUMPS)
    ) u_cal_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (cal_we),
        .i_wr_pump (in_pump),
        .i_wr_band (in_band),
        .i_wr_data (in_cal),
        .i_rd_en   (cal_rd),
        .i_rd_pump (in_pump),
        .i_rd_band (band),
        .o_rd_data (factor)
    );

    t_result result;

    mpdc_run_ctrl u_run_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_item          (r_item),
        .i_factor        (factor),
        .i_no_flow_limit (r_no_flow),
        .o_result        (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, result.elapsed_ms, result.pulse_count,
                            result.active_pump, result.pump_on};
    assign m_axis_tuser  = result.event_code;

    // an accepted event always lands in the input stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_valid)
        else $error("accepted event not held in input stage");

    // ready only drops with both stages full
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_a_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // a started run reports the pump as on
    a_start_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == EV_STARTED)) |-> m_axis_tdata[0])
        else $error("start reported with pump off");

    // any ending or rejecting event reports the pump as off
    a_end_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((m_axis_tuser == EV_VOLUME) || (m_axis_tuser == EV_NO_FLOW)
            || (m_axis_tuser == EV_TIME) || (m_axis_tuser == EV_REJECT)
            || (m_axis_tuser == EV_STOPPED) || (m_axis_tuser == EV_CAL)))
        |-> !m_axis_tdata[0])
        else $error("run end reported with pump on");

endmodule
